/* rtl/sha_pkg.sv */
// ----------------------------------------------------------------------------
// sha_pkg: shared constants and functions for the SHA-256 stream hasher
// Holds the round constants, the initial hash values and the rotate function.
// ----------------------------------------------------------------------------
`default_nettype none

package sha_pkg;

    localparam int WORD_W     = 32;
    localparam int NUM_ROUNDS = 64;
    localparam int BLOCK_BYTES = 64;
    localparam int LEN_W      = 64;

    typedef logic [WORD_W-1:0] word_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [6:0] LEN_POS  = 7'd56;

    function automatic word_t round_k(input logic [5:0] r);
        word_t k;
        begin
            unique case (r)
                6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
                6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
                6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
                6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
            endcase
            return k;
        end
    endfunction

    function automatic word_t init_h(input logic [2:0] i);
        word_t v;
        begin
            unique case (i)
                3'd0: v = 32'h6a09e667; 3'd1: v = 32'hbb67ae85;
                3'd2: v = 32'h3c6ef372; 3'd3: v = 32'ha54ff53a;
                3'd4: v = 32'h510e527f; 3'd5: v = 32'h9b05688c;
                3'd6: v = 32'h1f83d9ab; default: v = 32'h5be0cd19;
            endcase
            return v;
        end
    endfunction

    function automatic word_t ror(input word_t v, input int n);
        return (v >> n) | (v << (WORD_W - n));
    endfunction

endpackage

`default_nettype wire

/* rtl/sha256_stream_hasher.sv */
// ----------------------------------------------------------------------------
// sha256_stream_hasher: SHA-256 over a byte stream
// Input items carry an optional byte and an end mark; output items are the
// eight digest words, most significant first, with a last marker.
//
// Usage: drive in_valid with data_byte/byte_present/end_of_message. An item
// that carries no byte into a full block starts no compression. An item whose
// byte fills the 64-byte block starts the compression: a load of the working
// variables, 64 rounds, one per cycle in the shared round unit, and a fold
// into the chain; in_stall is high meanwhile. At end of message the pad bytes
// are written one per cycle from the marker position to the end of the block,
// then the compression runs. When the length field does not fit, a second
// block of pad bytes and a second compression follow. Then the eight digest
// words leave on the output channel, one per cycle while out_stall is low;
// in_stall stays high until the last word is taken. A stalled word is held
// unchanged. After the last word the state returns to the initial hash values
// for the next message.
// Reset clears the chain to the initial values and all counters.
// A message of overflowing length yields an all-zero digest.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_present,
    input  wire logic        end_of_message,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_number,
    output logic             last_word
);
    import sha_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_FOLD  = 3'd3;
    localparam logic [2:0] S_PAD   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [6:0]  fill_reg;
    logic [63:0] len_reg;
    logic        ovf_reg;
    logic        fin_reg;       // end of message seen; held until the digest is out
    logic        lenw_reg;      // length field is part of this pad block
    logic [5:0]  round_reg;
    logic [2:0]  oidx_reg;
    word_t       chain_reg [8];
    word_t       vars [8];
    word_t       w_word;
    word_t       mem [16];
    logic [7:0]  wr_byte;
    logic        wr_en;
    logic [5:0]  wr_addr;
    logic [63:0] bits;
    logic [7:0]  pad_byte;
    logic [5:0]  pad_pos;
    logic        accept;
    logic        mark_en_reg;
    logic [5:0]  mark_pos_reg;
    logic        first_pad;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign bits     = {len_reg[60:0], 3'b000};
    assign pad_pos  = fill_reg[5:0];

    // Padding byte for the current position
    always_comb
    begin
        if (lenw_reg && pad_pos >= 6'(LEN_POS))
            pad_byte = bits[8*(7 - (pad_pos - 6'(LEN_POS))) +: 8];
        else
            pad_byte = 8'h00;
    end

    // Block store: sixteen words, one byte lane written per cycle
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = fill_reg[5:0];
        wr_byte = data_byte;
        if (accept && byte_present && !ovf_reg && len_reg != '1)
            wr_en = 1'b1;
        else if (state_reg == S_PAD)
        begin
            wr_en   = 1'b1;
            wr_byte = first_pad ? PAD_BYTE : pad_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr[5:2]][8*(3 - wr_addr[1:0]) +: 8] <= wr_byte;
    end

    assign w_word = mem[round_reg[3:0]];

    sha_round u_round (
        .clk   (clk),
        .init  (state_reg == S_LOAD),
        .step  (state_reg == S_ROUND),
        .round (round_reg),
        .w_in  (w_word),
        .chain (chain_reg),
        .vars  (vars)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (byte_present && !ovf_reg && len_reg != '1 && fill_reg == 7'd63)
                        state_next = S_LOAD;
                    else if (end_of_message)
                        state_next = ovf_reg || (byte_present && len_reg == '1)
                                   ? S_OUT : S_PAD;
                end
            end
            S_LOAD:  state_next = S_ROUND;
            S_ROUND: if (round_reg == 6'd63) state_next = S_FOLD;
            S_FOLD:  state_next = fin_reg ? (lenw_reg ? S_OUT : S_PAD) : S_IDLE;
            S_PAD:   if (pad_pos == 6'd63) state_next = S_LOAD;
            S_OUT:   if (!out_stall && oidx_reg == 3'd7) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            fin_reg   <= 1'b0;
            lenw_reg  <= 1'b0;
            round_reg <= '0;
            oidx_reg  <= '0;
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= init_h(3'(i));
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        // take the byte, or flag overflow
                        if (byte_present && !ovf_reg)
                        begin
                            if (len_reg == '1)
                                ovf_reg <= 1'b1;
                            else
                            begin
                                len_reg  <= len_reg + 64'd1;
                                fill_reg <= (fill_reg == 7'd63) ? 7'd0 : fill_reg + 7'd1;
                            end
                        end
                        if (end_of_message)
                            fin_reg <= 1'b1;
                        // the pad byte goes in during the first pad cycle
                        if (end_of_message && !ovf_reg &&
                            !(byte_present && len_reg == '1))
                        begin
                            if (byte_present && fill_reg == 7'd63)
                                lenw_reg <= 1'b0;
                            else
                                lenw_reg <= (byte_present ? fill_reg + 7'd1 : fill_reg)
                                          < LEN_POS;
                        end
                    end
                    round_reg <= '0;
                end
                S_LOAD:  round_reg <= '0;
                S_ROUND: round_reg <= round_reg + 6'd1;
                S_FOLD:
                begin
                    for (int i = 0; i < 8; i++)
                        chain_reg[i] <= chain_reg[i] + vars[i];
                    if (fin_reg && !lenw_reg)
                    begin
                        lenw_reg <= 1'b1;
                        fill_reg <= '0;
                    end
                end
                S_PAD:
                begin
                    fill_reg <= (pad_pos == 6'd63) ? 7'd0 : fill_reg + 7'd1;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            fill_reg <= '0;
                            len_reg  <= '0;
                            ovf_reg  <= 1'b0;
                            fin_reg  <= 1'b0;
                            lenw_reg <= 1'b0;
                            for (int i = 0; i < 8; i++)
                                chain_reg[i] <= init_h(3'(i));
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // 0x80 marker: armed by the item that ends the message, dropped once written or when the digest goes out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mark_en_reg <= 1'b0;
        else if (accept && end_of_message)
            mark_en_reg <= 1'b1;
        else if (first_pad || state_reg == S_OUT)
            mark_en_reg <= 1'b0;
    end
    always_ff @(posedge clk)
    begin
        if (accept)
            mark_pos_reg <= (byte_present && !ovf_reg && len_reg != '1)
                          ? 6'(fill_reg + 7'd1) : fill_reg[5:0];
    end

    // Put the marker in place of the first pad byte
    assign first_pad = mark_en_reg && state_reg == S_PAD && pad_pos == mark_pos_reg;

    assign out_valid   = (state_reg == S_OUT);
    assign digest_word = ovf_reg ? 32'd0 : chain_reg[oidx_reg];
    assign word_number = oidx_reg;
    assign last_word   = (oidx_reg == 3'd7);

`ifndef SYNTH
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> in_stall)
        else $error("input taken while busy");
    a_round_run: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROUND && round_reg != 6'd63 |=> state_reg == S_ROUND)
        else $error("round sequence broken");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(word_number))
        else $error("output word moved under stall");
`endif

endmodule

`default_nettype wire

/* rtl/sha_round.sv */
// ----------------------------------------------------------------------------
// sha_round: shared SHA-256 round datapath
// Holds the working variables and schedule window; runs one round per cycle while step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_round (
    input  wire logic              clk,
    input  wire logic              init,       // load working vars from chain
    input  wire logic              step,       // run one round
    input  wire logic [5:0]        round,
    input  wire sha_pkg::word_t    w_in,       // message word for rounds 0..15
    input  wire sha_pkg::word_t    chain [8],
    output sha_pkg::word_t         vars [8]
);
    import sha_pkg::*;

    word_t v_reg [8];
    word_t win_reg [16];
    word_t w, s0, s1, t1, t2, w15, w2;

    // Schedule word and round function
    always_comb
    begin
        w15 = win_reg[4'(round - 6'd15)];
        w2  = win_reg[4'(round - 6'd2)];
        s0  = ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3);
        s1  = ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10);
        if (round < 6'd16)
            w = w_in;
        else
            w = win_reg[round[3:0]] + s0 + win_reg[4'(round - 6'd7)] + s1;
        t1 = v_reg[7] + (ror(v_reg[4], 6) ^ ror(v_reg[4], 11) ^ ror(v_reg[4], 25))
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + round_k(round) + w;
        t2 = (ror(v_reg[0], 2) ^ ror(v_reg[0], 13) ^ ror(v_reg[0], 22))
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // Advance the working variables
    always_ff @(posedge clk)
    begin
        if (init)
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= chain[i];
        end
        else if (step)
        begin
            win_reg[round[3:0]] <= w;
            v_reg[0] <= t1 + t2;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[5] <= v_reg[4];
            v_reg[6] <= v_reg[5];
            v_reg[7] <= v_reg[6];
        end
    end

    assign vars = v_reg;

endmodule

`default_nettype wire
